[rtl/cbf_pkg.sv]
package cbf_pkg;

    // Coordinate, error and tolerance widths.
    localparam int COORD_W = 32;
    localparam int ERR_W   = 36;
    localparam int TOL_W   = 32;

    // Subdivision depth bound and the widths that follow from it.
    localparam int MAX_DEPTH = 6;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = $clog2(MAX_DEPTH);

    localparam int NUM_PTS  = 4;
    localparam int NUM_AXES = 2;

    // Tolerance after reset: 1.0 in 16.16.
    localparam logic [TOL_W-1:0] GB_ONE = TOL_W'(65536);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic [CNT_W-1:0]          t_cnt;

    // Sign-extend a coordinate to the error width.
    function automatic t_err sx(input t_coord v);
        return {{(ERR_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

endpackage

[rtl/cbf_if.sv]
// Curve channel: one item is a whole cubic curve.
interface cbf_curve_if import cbf_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord first_ctrl_x;
    t_coord first_ctrl_y;
    t_coord second_ctrl_x;
    t_coord second_ctrl_y;
    t_coord finish_x;
    t_coord finish_y;

    modport source (
        output valid, start_x, start_y, first_ctrl_x, first_ctrl_y,
               second_ctrl_x, second_ctrl_y, finish_x, finish_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, first_ctrl_x, first_ctrl_y,
               second_ctrl_x, second_ctrl_y, finish_x, finish_y,
        output ready
    );
endinterface

// Segment channel: one item is the end point of one line segment.
interface cbf_seg_if import cbf_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord seg_end_x;
    t_coord seg_end_y;
    logic   last_segment;

    modport source (
        output valid, seg_end_x, seg_end_y, last_segment,
        input  ready
    );
    modport sink (
        input  valid, seg_end_x, seg_end_y, last_segment,
        output ready
    );
endinterface

[rtl/cubic_bezier_flattener.sv]
// Flatness test of one piece: states EB, EBA, EE, EEA and MIN per axis, then the tolerance compare.
// Halving of one piece: midpoint steps MID, LC, RC, LM, RM and CUT per axis, all on one shared adder.
// A curve is accepted in IDLE and gives at most 64 segments; pieces at the depth bound skip the
// flatness test, and output stalls hold the sequencer in EMIT until the output register is free.
// The next curve is taken once the last is queued. Reset (synchronous, active low) idles the
// sequencer, empties the output register and sets the tolerance to 1.0; the stack is not reset.
module cubic_bezier_flattener import cbf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TOL_W-1:0] i_cfg_wr_data,
    cbf_curve_if.sink        i_curve,
    cbf_seg_if.source        o_seg
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EB    = 4'd1;
    localparam logic [3:0] ST_EBA   = 4'd2;
    localparam logic [3:0] ST_EE    = 4'd3;
    localparam logic [3:0] ST_EEA   = 4'd4;
    localparam logic [3:0] ST_MIN   = 4'd5;
    localparam logic [3:0] ST_CMP   = 4'd6;
    localparam logic [3:0] ST_SPLIT = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    // Halving steps, one midpoint each.
    localparam logic [2:0] SUB_MID = 3'd0;
    localparam logic [2:0] SUB_LC  = 3'd1;
    localparam logic [2:0] SUB_RC  = 3'd2;
    localparam logic [2:0] SUB_LM  = 3'd3;
    localparam logic [2:0] SUB_RM  = 3'd4;
    localparam logic [2:0] SUB_CUT = 3'd5;

    // Point positions within a piece.
    localparam int PT_P0 = 0;
    localparam int PT_C1 = 1;
    localparam int PT_C2 = 2;
    localparam int PT_P3 = 3;

    logic [3:0]       r_state;
    logic [2:0]       r_sub;
    logic             r_axis;
    logic [TOL_W-1:0] r_tol;
    t_cnt             r_level;
    t_cnt             r_count;
    t_coord           r_cur     [NUM_AXES][NUM_PTS];
    t_coord           r_stk     [MAX_DEPTH][NUM_AXES][NUM_PTS];
    t_cnt             r_stk_lvl [MAX_DEPTH];
    t_err             r_t;
    t_err             r_e0;
    t_err             r_ex;
    t_coord           r_mid;
    t_coord           r_lc;
    t_coord           r_rc;
    t_coord           r_lm;
    t_coord           r_rm;
    logic             r_out_valid;
    t_coord           r_out_x;
    t_coord           r_out_y;
    logic             r_out_last;

    t_coord w_p0;
    t_coord w_c1;
    t_coord w_c2;
    t_coord w_p3;
    t_err   u_a;
    t_err   u_b;
    t_err   u_c;
    t_err   u_d;
    t_err   u_res;
    t_coord u_half;
    t_err   w_min;
    logic   w_flat;
    logic   w_out_free;
    logic   w_emit;
    t_cnt   w_level_up;
    t_cnt   w_pop_lvl;
    logic [IDX_W-1:0] w_top;
    logic [IDX_W-1:0] w_slot;

    // Points of the piece on the current axis.
    assign w_p0 = r_cur[r_axis][PT_P0];
    assign w_c1 = r_cur[r_axis][PT_C1];
    assign w_c2 = r_cur[r_axis][PT_C2];
    assign w_p3 = r_cur[r_axis][PT_P3];

    // Operand selection for the shared adder.
    always_comb begin
        u_a = '0;
        u_b = '0;
        u_c = '0;
        u_d = '0;
        unique case (r_state)
            ST_EB: begin
                u_a = sx(w_c1) <<< 1;
                u_b = sx(w_c1);
                u_c = sx(w_p0) <<< 1;
                u_d = sx(w_p3);
            end
            ST_EE: begin
                u_a = sx(w_c2) <<< 1;
                u_b = sx(w_c2);
                u_c = sx(w_p3) <<< 1;
                u_d = sx(w_p0);
            end
            ST_EBA, ST_EEA: begin
                u_c = r_t;
            end
            ST_MIN: begin
                u_a = r_t;
                u_c = r_e0;
            end
            ST_CMP: begin
                u_a = r_ex;
                u_b = r_e0;
                u_c = {{(ERR_W - TOL_W){1'b0}}, r_tol};
            end
            ST_SPLIT: begin
                case (r_sub)
                    SUB_MID: begin
                        u_a = sx(w_c1);
                        u_b = sx(w_c2);
                    end
                    SUB_LC: begin
                        u_a = sx(w_p0);
                        u_b = sx(w_c1);
                    end
                    SUB_RC: begin
                        u_a = sx(w_c2);
                        u_b = sx(w_p3);
                    end
                    SUB_LM: begin
                        u_a = sx(r_mid);
                        u_b = sx(r_lc);
                    end
                    SUB_RM: begin
                        u_a = sx(r_mid);
                        u_b = sx(r_rc);
                    end
                    default: begin
                        u_a = sx(r_lm);
                        u_b = sx(r_rm);
                    end
                endcase
            end
            default: begin
                u_a = '0;
            end
        endcase
    end

    // Shared adder; halving takes the floor of the sum over two.
    assign u_res  = u_a + u_b - u_c - u_d;
    assign u_half = u_res[COORD_W:1];

    // Smaller of the two absolute errors, and the tolerance check.
    assign w_min  = u_res[ERR_W-1] ? r_t : r_e0;
    assign w_flat = u_res[ERR_W-1] || (u_res == '0);

    assign w_out_free = !r_out_valid || o_seg.ready;
    assign w_emit     = (r_state == ST_EMIT) && w_out_free;
    assign w_level_up = r_level + 1'b1;
    assign w_top      = IDX_W'(r_count - 1'b1);
    assign w_slot     = IDX_W'(r_count);
    assign w_pop_lvl  = r_stk_lvl[w_top];

    assign i_curve.ready     = (r_state == ST_IDLE);
    assign o_seg.valid       = r_out_valid;
    assign o_seg.seg_end_x   = r_out_x;
    assign o_seg.seg_end_y   = r_out_y;
    assign o_seg.last_segment = r_out_last;

    // Sequencer, piece registers and stack.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sub       <= SUB_MID;
            r_axis      <= 1'b0;
            r_tol       <= GB_ONE;
            r_level     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            // The output register empties when its item is taken and nothing new is queued.
            if (o_seg.ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_curve.valid) begin
                        r_cur[0][PT_P0] <= i_curve.start_x;
                        r_cur[1][PT_P0] <= i_curve.start_y;
                        r_cur[0][PT_C1] <= i_curve.first_ctrl_x;
                        r_cur[1][PT_C1] <= i_curve.first_ctrl_y;
                        r_cur[0][PT_C2] <= i_curve.second_ctrl_x;
                        r_cur[1][PT_C2] <= i_curve.second_ctrl_y;
                        r_cur[0][PT_P3] <= i_curve.finish_x;
                        r_cur[1][PT_P3] <= i_curve.finish_y;
                        r_level <= '0;
                        r_count <= '0;
                        r_axis  <= 1'b0;
                        r_state <= ST_EB;
                    end
                end
                ST_EB: begin
                    r_t     <= u_res;
                    r_state <= ST_EBA;
                end
                ST_EBA: begin
                    r_e0    <= r_t[ERR_W-1] ? u_res : r_t;
                    r_state <= ST_EE;
                end
                ST_EE: begin
                    r_t     <= u_res;
                    r_state <= ST_EEA;
                end
                ST_EEA: begin
                    r_t     <= r_t[ERR_W-1] ? u_res : r_t;
                    r_state <= ST_MIN;
                end
                ST_MIN: begin
                    if (!r_axis) begin
                        r_ex    <= w_min;
                        r_axis  <= 1'b1;
                        r_state <= ST_EB;
                    end else begin
                        r_e0    <= w_min;
                        r_axis  <= 1'b0;
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    r_sub   <= SUB_MID;
                    r_state <= w_flat ? ST_EMIT : ST_SPLIT;
                end
                ST_SPLIT: begin
                    case (r_sub)
                        SUB_MID: r_mid <= u_half;
                        SUB_LC:  r_lc  <= u_half;
                        SUB_RC:  r_rc  <= u_half;
                        SUB_LM:  r_lm  <= u_half;
                        SUB_RM:  r_rm  <= u_half;
                        default: begin
                        end
                    endcase
                    if (r_sub != SUB_CUT) begin
                        r_sub <= r_sub + 3'd1;
                    end else begin
                        // Right half goes on the stack, left half stays.
                        if (r_count < CNT_W'(MAX_DEPTH)) begin
                            r_stk[w_slot][r_axis][PT_P0] <= u_half;
                            r_stk[w_slot][r_axis][PT_C1] <= r_rm;
                            r_stk[w_slot][r_axis][PT_C2] <= r_rc;
                            r_stk[w_slot][r_axis][PT_P3] <= w_p3;
                        end
                        r_cur[r_axis][PT_C1] <= r_lc;
                        r_cur[r_axis][PT_C2] <= r_lm;
                        r_cur[r_axis][PT_P3] <= u_half;
                        r_sub <= SUB_MID;
                        if (!r_axis) begin
                            r_axis <= 1'b1;
                        end else begin
                            r_axis  <= 1'b0;
                            r_level <= w_level_up;
                            if (r_count < CNT_W'(MAX_DEPTH)) begin
                                r_stk_lvl[w_slot] <= w_level_up;
                                r_count           <= r_count + 1'b1;
                            end
                            r_state <= (w_level_up >= CNT_W'(MAX_DEPTH)) ? ST_EMIT : ST_EB;
                        end
                    end
                end
                ST_EMIT: begin
                    // Queue the end point once the output register is free.
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_cur[0][PT_P3];
                        r_out_y     <= r_cur[1][PT_P3];
                        r_out_last  <= (r_count == '0);
                        r_axis      <= 1'b0;
                        if (r_count == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cur   <= r_stk[w_top];
                            r_level <= w_pop_lvl;
                            r_count <= r_count - 1'b1;
                            r_state <= (w_pop_lvl >= CNT_W'(MAX_DEPTH)) ? ST_EMIT : ST_EB;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/tb.sv]
module tb import cbf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEGS      = 1 << MAX_DEPTH;
    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int SETTLE_CYCLES = 2500;
    localparam t_coord ONE   = 32'sd65536;
    localparam t_coord C_MAX = 32'sh7FFF_FFFF;
    localparam t_coord C_MIN = t_coord'(32'h8000_0000);

    // One curve: index 0 is the start, 1 and 2 the control points, 3 the end.
    typedef struct {
        t_coord x [4];
        t_coord y [4];
    } t_curve;

    // One predicted line segment end point.
    typedef struct {
        t_coord end_x;
        t_coord end_y;
        logic   last;
    } t_seg;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [TOL_W-1:0] i_cfg_wr_data;

    cbf_curve_if curve_ch ();
    cbf_seg_if   seg_ch ();

    cubic_bezier_flattener u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_curve       (curve_ch),
        .o_seg         (seg_ch)
    );

    // Predicted segments in curve order, and the tolerance the block holds.
    t_seg             predicted_ends [$];
    logic [TOL_W-1:0] flat_tol = GB_ONE;

    int fail_count   = 0;
    int curves_sent  = 0;
    int segs_checked = 0;
    int deep_curves  = 0;
    int tol_settings = 1;
    int cycle_count  = 0;
    int send_quiet   = 0;
    int recv_quiet   = 0;
    t_seg seg_want;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // Floor of the mean of two coordinates, exact over the full range.
    function automatic t_coord midpoint(input t_coord a, input t_coord b);
        return t_coord'((longint'(a) + longint'(b)) >>> 1);
    endfunction

    // Smaller of the two control point deviations on one axis.
    function automatic longint axis_deviation(input t_coord p [4]);
        longint dev_start;
        longint dev_end;
        dev_start = 3 * longint'(p[1]) - 2 * longint'(p[0]) - longint'(p[3]);
        dev_end   = 3 * longint'(p[2]) - 2 * longint'(p[3]) - longint'(p[0]);
        if (dev_start < 0) dev_start = -dev_start;
        if (dev_end < 0) dev_end = -dev_end;
        return (dev_end < dev_start) ? dev_end : dev_start;
    endfunction

    // De Casteljau halving of one axis into a left and a right half.
    function automatic void halve_axis(input t_coord p [4], output t_coord l [4],
                                       output t_coord r [4]);
        t_coord mid, lc, rc, lm, rm, cut;
        mid = midpoint(p[1], p[2]);
        lc  = midpoint(p[0], p[1]);
        rc  = midpoint(p[2], p[3]);
        lm  = midpoint(mid, lc);
        rm  = midpoint(mid, rc);
        cut = midpoint(lm, rm);
        l = '{p[0], lc, lm, cut};
        r = '{cut, rm, rc, p[3]};
    endfunction

    // Flattens one curve and queues every segment end point it yields.
    function automatic void flatten_curve(input t_curve c);
        t_curve piece, lo, hi;
        t_curve stack_piece [MAX_DEPTH];
        int     stack_level [MAX_DEPTH];
        int     depth, level, n;
        longint err;
        bit     done;
        piece = c;
        depth = 0;
        level = 0;
        n     = 0;
        done  = 1'b0;
        while (!done) begin
            err = axis_deviation(piece.x) + axis_deviation(piece.y);
            if (level < MAX_DEPTH && err > longint'(flat_tol)) begin
                // Too curved: keep the left half, park the right half.
                halve_axis(piece.x, lo.x, hi.x);
                halve_axis(piece.y, lo.y, hi.y);
                level++;
                if (depth < MAX_DEPTH) begin
                    stack_piece[depth] = hi;
                    stack_level[depth] = level;
                    depth++;
                end
                piece = lo;
            end else begin
                predicted_ends.push_back('{piece.x[3], piece.y[3], logic'(depth == 0)});
                n++;
                if (depth == 0 || n >= MAX_SEGS) begin
                    done = 1'b1;
                end else begin
                    depth--;
                    piece = stack_piece[depth];
                    level = stack_level[depth];
                end
            end
        end
        if (n == MAX_SEGS) deep_curves++;
    endfunction

    function automatic t_curve make_curve(input t_coord x0, y0, x1, y1, x2, y2, x3, y3);
        t_curve c;
        c.x = '{x0, x1, x2, x3};
        c.y = '{y0, y1, y2, y3};
        return c;
    endfunction

    // Random curve: mostly local ones of random size, some fully random, some degenerate.
    function automatic t_curve rand_curve();
        t_curve c;
        int kind, spread, bx, by;
        kind   = $urandom_range(0, 9);
        spread = $urandom_range(0, 29);
        bx     = int'($urandom) >>> 2;
        by     = int'($urandom) >>> 2;
        for (int i = 0; i < 4; i++) begin
            if (kind == 0) begin
                c.x[i] = $urandom;
                c.y[i] = $urandom;
            end else if (kind == 1) begin
                c.x[i] = bx;
                c.y[i] = by;
            end else begin
                c.x[i] = bx + (int'($urandom) >>> (31 - spread));
                c.y[i] = by + (int'($urandom) >>> (31 - spread));
            end
        end
        return c;
    endfunction

    // Wait before the next item or ready: random, with runs of no waiting.
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic drive_fields(input t_curve c);
        curve_ch.start_x       <= c.x[0];
        curve_ch.start_y       <= c.y[0];
        curve_ch.first_ctrl_x  <= c.x[1];
        curve_ch.first_ctrl_y  <= c.y[1];
        curve_ch.second_ctrl_x <= c.x[2];
        curve_ch.second_ctrl_y <= c.y[2];
        curve_ch.finish_x      <= c.x[3];
        curve_ch.finish_y      <= c.y[3];
    endtask

    // Sends one curve item and predicts its segments once it is taken.
    task automatic send_curve(input t_curve c);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            curve_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        drive_fields(c);
        curve_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(curve_ch.valid && curve_ch.ready));
        flatten_curve(c);
        curves_sent++;
    endtask

    // Holds off new curves until every predicted segment has come out.
    task automatic wait_for_drain();
        curve_ch.valid <= 1'b0;
        do @(posedge i_clk); while (predicted_ends.size() != 0);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        wait_for_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        flat_tol = value;
        tol_settings++;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_curve(rand_curve());
            if (i == count / 2) wait_for_drain();
        end
    endtask

    // Reset tolerance: degenerate, straight, curved and full-range curves.
    task automatic test_reset_tolerance();
        send_curve(make_curve(5 * ONE, -7 * ONE, 5 * ONE, -7 * ONE,
                              5 * ONE, -7 * ONE, 5 * ONE, -7 * ONE));
        send_curve(make_curve(0, 0, ONE, 2 * ONE, 2 * ONE, 4 * ONE, 3 * ONE, 6 * ONE));
        send_curve(make_curve(0, 0, 0, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 0));
        send_curve(make_curve(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX));
        send_curve(make_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_curve(make_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_curve(make_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX));
    endtask

    // Zero tolerance: only exact lines stay whole, the rest hit the depth bound.
    task automatic test_zero_tolerance();
        set_tolerance('0);
        send_curve(make_curve(0, 0, ONE, 2 * ONE, 2 * ONE, 4 * ONE, 3 * ONE, 6 * ONE));
        send_curve(make_curve(-ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        send_curve(make_curve(0, 0, 0, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 0));
        send_curve(make_curve(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX));
    endtask

    // Largest tolerance: full-range curves still exceed it.
    task automatic test_max_tolerance();
        set_tolerance('1);
        send_curve(make_curve(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX));
        send_curve(make_curve(0, 0, 0, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 0));
        send_curve(make_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX));
    endtask

    // Error equal to the tolerance is flat; one below it splits.
    task automatic test_tolerance_edge();
        set_tolerance(TOL_W'(15 * 65536));
        send_curve(make_curve(0, 0, 5 * ONE, 0, 5 * ONE, 0, 0, 0));
        set_tolerance(TOL_W'(15 * 65536 - 1));
        send_curve(make_curve(0, 0, 5 * ONE, 0, 5 * ONE, 0, 0, 0));
    endtask

    // Random curves under several tolerance settings.
    task automatic test_random_curves();
        set_tolerance($urandom);
        run_random(90);
        set_tolerance('0);
        run_random(20);
        set_tolerance('1);
        run_random(80);
        set_tolerance(TOL_W'(1) << $urandom_range(4, 26));
        run_random(140);
        set_tolerance(GB_ONE);
        run_random(140);
    endtask

    // Segment sink with random stalls.
    initial begin : seg_drain
        int stall;
        seg_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(recv_quiet);
            if (stall > 0) begin
                seg_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            seg_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(seg_ch.valid && seg_ch.ready));
        end
    end

    // Compare each accepted segment with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && seg_ch.valid && seg_ch.ready) begin
            if (predicted_ends.size() == 0) begin
                $display("%0t: unexpected segment, expected none, got %h %h %b", $time,
                         seg_ch.seg_end_x, seg_ch.seg_end_y, seg_ch.last_segment);
                fail_count++;
            end else begin
                seg_want = predicted_ends.pop_front();
                check_field("seg_end_x", seg_want.end_x, seg_ch.seg_end_x);
                check_field("seg_end_y", seg_want.end_y, seg_ch.seg_end_y);
                check_field("last_segment", 32'(seg_want.last), 32'(seg_ch.last_segment));
                segs_checked++;
            end
        end
    end

    // Test sequence.
    initial begin
        curve_ch.valid <= 1'b0;
        drive_fields(make_curve(0, 0, 0, 0, 0, 0, 0, 0));
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_rst_n       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_tolerance();
        test_zero_tolerance();
        test_max_tolerance();
        test_tolerance_edge();
        test_random_curves();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (predicted_ends.size() != 0) begin
            $display("%0t: %0d segments expected, got none", $time, predicted_ends.size());
            fail_count++;
        end

        $display("Sent %0d curves under %0d tolerance settings; checked %0d segments.",
                 curves_sent, tol_settings, segs_checked);
        $display("%0d curves were cut down to the depth bound.", deep_curves);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
